/* rtl/handle_id_allocator_defines.svh */
// ----------------------------------------------------------------------------
// handle_id_allocator_defines
// assertion macros used by the handle allocator datapath
// ----------------------------------------------------------------------------
`ifndef HANDLE_ID_ALLOCATOR_DEFINES_SVH
`define HANDLE_ID_ALLOCATOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define HIA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hia_pkg.sv */
// ----------------------------------------------------------------------------
// hia_pkg
// types and constants shared by the handle allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package hia_pkg;

  localparam int INDEX_W  = 8;
  localparam int SERIAL_W = 32;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [INDEX_W-1:0]    slot_index;
    logic [SERIAL_W-1:0]   serial_in;
  } request_t;

  typedef struct packed {
    status_t               status;
    logic [INDEX_W-1:0]    handle_index;
    logic [SERIAL_W-1:0]   handle_serial;
    logic                  is_valid;
  } response_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic create;
    logic destroy;
    logic check;
    logic clear;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/hia_ram.sv */
// ----------------------------------------------------------------------------
// hia_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/hia_ctrl.sv */
// ----------------------------------------------------------------------------
// hia_ctrl
// request sequencer: capture and lookup, then execute one opcode
// ----------------------------------------------------------------------------
`default_nettype none

module hia_ctrl import hia_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (start) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        cmd.load = start;
      end
      FSM_EXEC: begin
        busy = 1'b1;
        unique case (status.op)
          OP_CREATE:  cmd.create  = 1'b1;
          OP_DESTROY: cmd.destroy = 1'b1;
          OP_CHECK:   cmd.check   = 1'b1;
          OP_CLEAR:   cmd.clear   = 1'b1;
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/hia_dp.sv */
// ----------------------------------------------------------------------------
// hia_dp
// allocator datapath: slot table, free stack, counters and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "handle_id_allocator_defines.svh"

module hia_dp import hia_pkg::*; #(
  parameter int MAX_HANDLES = 256,
  parameter int SERIAL_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire request_t  request,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     status,
  output response_t      response,
  output logic           done
);

  localparam int IDX_W  = $clog2(MAX_HANDLES);
  localparam int CNT_W  = $clog2(MAX_HANDLES + 1);
  localparam int IXW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int HCW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int SW     = (SERIAL_BITS > SERIAL_W) ? SERIAL_BITS : SERIAL_W;
  localparam int SLOT_W = SERIAL_BITS + 1;
  localparam logic [CNT_W-1:0]       POOL_SIZE   = CNT_W'(MAX_HANDLES);
  localparam logic [SERIAL_BITS-1:0] SERIAL_LAST = '1;

  // latched request
  opcode_t             req_op;
  logic [INDEX_W-1:0]  req_idx;
  logic [SERIAL_W-1:0] req_ser;

  // allocator state
  logic [CNT_W-1:0]       free_count;
  logic [CNT_W-1:0]       high_water;
  logic [SERIAL_BITS-1:0] next_serial;

  // ram ports
  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [IDX_W-1:0]  slot_raddr;
  logic [SLOT_W-1:0] slot_rdata;
  logic              stack_we;
  logic [IDX_W-1:0]  stack_waddr;
  logic [IDX_W-1:0]  stack_wdata;
  logic [IDX_W-1:0]  stack_raddr;
  logic [IDX_W-1:0]  stack_rdata;

  logic [IXW-1:0]         in_idx_wide;
  logic [IXW-1:0]         req_idx_wide;
  logic [CNT_W-1:0]       top_pos;
  logic                   idx_written;
  logic                   slot_live;
  logic [SERIAL_BITS-1:0] stored_ser;
  logic                   ser_match;
  logic                   ser_issued;
  logic                   stack_nonempty;
  logic                   have_slot;
  logic                   create_ok;
  logic                   destroy_ok;
  logic [IDX_W-1:0]       new_slot;
  logic [IXW-1:0]         new_slot_wide;
  logic [SW-1:0]          next_ser_wide;
  response_t              response_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= request.opcode;
      req_idx <= request.slot_index;
      req_ser <= request.serial_in;
    end
  end

  assign status.op = req_op;

  // lookups are issued in the capture cycle: the slot table straight from the request word, the free stack at its top
  assign in_idx_wide  = IXW'(request.slot_index);
  assign slot_raddr   = in_idx_wide[IDX_W-1:0];
  assign top_pos      = free_count - CNT_W'(1);
  assign stack_raddr  = top_pos[IDX_W-1:0];
  assign req_idx_wide = IXW'(req_idx);

  // entries at or above high_water were never written since reset or clear
  assign idx_written    = HCW'(req_idx) < HCW'(high_water);
  assign slot_live      = idx_written && slot_rdata[SERIAL_BITS];
  assign stored_ser     = slot_rdata[SERIAL_BITS-1:0];
  assign ser_match      = SW'(stored_ser) == SW'(req_ser);
  assign ser_issued     = SW'(req_ser) < SW'(next_serial);
  assign stack_nonempty = free_count != '0;
  assign have_slot      = stack_nonempty || (high_water != POOL_SIZE);
  assign create_ok      = have_slot && (next_serial != SERIAL_LAST);
  assign destroy_ok     = slot_live && ser_match && (free_count != POOL_SIZE);
  assign new_slot       = stack_nonempty ? stack_rdata : high_water[IDX_W-1:0];
  assign new_slot_wide  = IXW'(new_slot);
  assign next_ser_wide  = SW'(next_serial);

  always_comb begin
    slot_we     = (cmd.create && create_ok) || (cmd.destroy && destroy_ok);
    slot_waddr  = cmd.create ? new_slot : req_idx_wide[IDX_W-1:0];
    slot_wdata  = cmd.create ? {1'b1, next_serial} : {1'b0, stored_ser};
    stack_we    = cmd.destroy && destroy_ok;
    stack_waddr = free_count[IDX_W-1:0];
    stack_wdata = req_idx_wide[IDX_W-1:0];
  end

  hia_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_HANDLES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.load),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  hia_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_HANDLES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (cmd.load),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count  <= '0;
      high_water  <= '0;
      next_serial <= '0;
    end else begin
      priority if (cmd.clear) begin
        free_count  <= '0;
        high_water  <= '0;
        next_serial <= '0;
      end else if (cmd.create && create_ok) begin
        if (stack_nonempty) begin
          free_count <= free_count - CNT_W'(1);
        end else begin
          high_water <= high_water + CNT_W'(1);
        end
        next_serial <= next_serial + SERIAL_BITS'(1);
      end else if (cmd.destroy && destroy_ok) begin
        free_count <= free_count + CNT_W'(1);
      end
    end
  end

  always_comb begin
    response_next = '0;
    if (cmd.create) begin
      if (create_ok) begin
        response_next.handle_index  = new_slot_wide[INDEX_W-1:0];
        response_next.handle_serial = next_ser_wide[SERIAL_W-1:0];
      end else begin
        response_next.status = ST_FULL;
      end
    end
    if (cmd.destroy && !destroy_ok) begin
      response_next.status = ST_NOT_FOUND;
    end
    if (cmd.check) begin
      response_next.is_valid = slot_live && ser_issued;
    end
  end

  always_ff @(posedge clk) begin
    response <= response_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.create || cmd.destroy || cmd.check || cmd.clear;
    end
  end

  `HIA_ASSERT_ALWAYS(a_free_le_water, free_count <= high_water, "free stack deeper than issued count")
  `HIA_ASSERT_ALWAYS(a_water_bound, high_water <= POOL_SIZE, "issued count beyond pool size")
  `HIA_ASSERT_NEXT(a_done_after_exec, cmd.create || cmd.destroy || cmd.check || cmd.clear, done, "no result word after execute")
  `HIA_ASSERT_NEXT(a_serial_step, cmd.create && create_ok, next_serial == $past(next_serial) + SERIAL_BITS'(1), "serial did not advance on create")

endmodule

`default_nettype wire

/* rtl/handle_id_allocator.sv */
// a word taken at a start edge is captured, executed in the exec state and
//   its result word registered with done high; no new word is taken in exec
// the slot table and free stack are read in the capture cycle and written in
//   the execute cycle, so a word holds the block through both states
// synchronous reset clears counters and control; no memory clearing pass,
//   results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// handle_id_allocator
// lifo free-list handle allocator with serial-stamped handles
// ----------------------------------------------------------------------------
`default_nettype none

module handle_id_allocator import hia_pkg::*; #(
  parameter int MAX_HANDLES = 256,
  parameter int SERIAL_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          done,
  output response_t     response
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hia_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  hia_dp #(
    .MAX_HANDLES (MAX_HANDLES),
    .SERIAL_BITS (SERIAL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .status   (status),
    .response (response),
    .done     (done)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives create, destroy, check and clear words into the handle allocator and
// checks every response against a cycle-free model of the handle table
// ----------------------------------------------------------------------------
`default_nettype none

class handle_table_model;
  localparam int NUM_SLOTS = 1 << hia_pkg::INDEX_W;

  bit                          live_mark [NUM_SLOTS];
  bit [hia_pkg::SERIAL_W-1:0]  slot_serial [NUM_SLOTS];
  bit [hia_pkg::INDEX_W-1:0]   free_stack [NUM_SLOTS];
  int unsigned                 free_count;
  int unsigned                 high_water;
  bit [hia_pkg::SERIAL_W-1:0]  next_serial;
  hia_pkg::response_t          expected_responses [$];
  int unsigned                 mismatches;

  function void wipe();
    foreach (live_mark[i]) begin
      live_mark[i] = 1'b0;
      slot_serial[i] = '0;
      free_stack[i] = '0;
    end
    free_count = 0;
    high_water = 0;
    next_serial = '0;
  endfunction

  // random live index, or -1 when nothing is allocated
  function int pick_live();
    int base;
    int idx;
    base = $urandom_range(NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      idx = (base + k) % NUM_SLOTS;
      if (live_mark[idx]) begin
        return idx;
      end
    end
    return -1;
  endfunction

  function void note_request(hia_pkg::request_t req);
    hia_pkg::response_t rsp;
    int unsigned slot;
    int unsigned idx;
    rsp = '0;
    rsp.status = hia_pkg::ST_OK;
    idx = req.slot_index;
    case (req.opcode)
      hia_pkg::OP_CREATE: begin
        if ((free_count == 0 && high_water == NUM_SLOTS) || next_serial == '1) begin
          rsp.status = hia_pkg::ST_FULL;
        end else begin
          if (free_count > 0) begin
            free_count--;
            slot = free_stack[free_count];
          end else begin
            slot = high_water;
            high_water++;
          end
          live_mark[slot] = 1'b1;
          slot_serial[slot] = next_serial;
          rsp.handle_index = hia_pkg::INDEX_W'(slot);
          rsp.handle_serial = next_serial;
          next_serial++;
        end
      end
      hia_pkg::OP_DESTROY: begin
        if (live_mark[idx] && slot_serial[idx] == req.serial_in && free_count < NUM_SLOTS) begin
          live_mark[idx] = 1'b0;
          free_stack[free_count] = req.slot_index;
          free_count++;
        end else begin
          rsp.status = hia_pkg::ST_NOT_FOUND;
        end
      end
      hia_pkg::OP_CHECK: begin
        rsp.is_valid = live_mark[idx] && (req.serial_in < next_serial);
      end
      default: begin
        wipe();
      end
    endcase
    expected_responses = {expected_responses, rsp};
  endfunction

  function void check_response(hia_pkg::response_t got);
    hia_pkg::response_t want;
    bit bad;
    if (expected_responses.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected response word %h", got);
      end
      mismatches++;
      return;
    end
    want = expected_responses.pop_front();
    bad = (got.status !== want.status) || (got.handle_index !== want.handle_index) ||
          (got.handle_serial !== want.handle_serial) || (got.is_valid !== want.is_valid);
    if (bad) begin
      if (mismatches < 10) begin
        $display("mismatch: expected status %0d index %0d serial %0d valid %0b",
                 want.status, want.handle_index, want.handle_serial, want.is_valid);
        $display("          actual   status %0d index %0d serial %0d valid %0b",
                 got.status, got.handle_index, got.handle_serial, got.is_valid);
      end
      mismatches++;
    end
  endfunction
endclass

module testbench;
  import hia_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 235;

  logic      clk;
  logic      rst;
  logic      start;
  request_t  request;
  logic      busy;
  logic      done;
  response_t response;

  handle_table_model sb;
  int unsigned cycle_count;
  int          burst_left;

  // create share and clear rate per segment; the 85/90 segments fill the pool
  int create_pct [SEGMENTS]     = '{50, 85, 85, 30, 60, 90, 40};
  int clear_permille [SEGMENTS] = '{5, 0, 0, 10, 5, 0, 20};

  handle_id_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_response(response);
    end
  end

  task automatic send_word(request_t req);
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sb.note_request(req);
  endtask

  // bursts of back-to-back words with random gaps between them
  task automatic sender_pause();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_responses.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic request_t word(opcode_t op, int idx, logic [SERIAL_W-1:0] ser);
    request_t req;
    req.opcode = op;
    req.slot_index = INDEX_W'(idx);
    req.serial_in = ser;
    return req;
  endfunction

  function automatic request_t random_word(int seg);
    request_t req;
    int roll;
    int slot;
    req.opcode = OP_CHECK;
    req.slot_index = INDEX_W'($urandom);
    req.serial_in = $urandom;
    roll = $urandom_range(999);
    if (roll < clear_permille[seg]) begin
      req.opcode = OP_CLEAR;
      return req;
    end
    roll = $urandom_range(99);
    if (roll < create_pct[seg]) begin
      req.opcode = OP_CREATE;
      return req;
    end
    if (roll < create_pct[seg] + (100 - create_pct[seg]) * 6 / 10) begin
      req.opcode = OP_DESTROY;
    end
    roll = $urandom_range(9);
    slot = sb.pick_live();
    if (slot >= 0 && roll < 7) begin
      req.slot_index = INDEX_W'(slot);
      req.serial_in = sb.slot_serial[slot];
    end else if (slot >= 0 && roll < 9) begin
      // live index with a random serial up to next_serial or one bit flipped
      req.slot_index = INDEX_W'(slot);
      req.serial_in = (req.opcode == OP_CHECK) ? $urandom_range(sb.next_serial) :
                      sb.slot_serial[slot] ^ (32'd1 << $urandom_range(4));
    end else if (roll[0]) begin
      req.serial_in = $urandom_range(sb.next_serial + 1);
    end
    return req;
  endfunction

  initial begin
    request_t directed [$];
    sb = new;
    cycle_count = 0;
    burst_left = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    directed = '{
      word(OP_CREATE, 8'hff, 32'hffff_ffff),
      word(OP_CREATE, 0, 0),
      word(OP_CREATE, 8'h5a, 32'h1234_5678),
      word(OP_CHECK, 0, 0),
      word(OP_CHECK, 0, 2),               // issued but mismatched serial on a live index still valid
      word(OP_CHECK, 0, 32'hffff_ffff),   // serial not yet given out
      word(OP_CHECK, 255, 0),
      word(OP_DESTROY, 0, 1),             // serial mismatch
      word(OP_DESTROY, 200, 0),           // index never allocated
      word(OP_DESTROY, 1, 1),
      word(OP_DESTROY, 1, 1),             // already freed
      word(OP_CHECK, 1, 1),
      word(OP_CREATE, 0, 0),              // reuses the freed index
      word(OP_DESTROY, 0, 0),
      word(OP_DESTROY, 2, 2),
      word(OP_CREATE, 8'haa, 32'h5555_5555),
      word(OP_CREATE, 8'h55, 32'haaaa_aaaa),
      word(OP_CREATE, 0, 0),
      word(OP_CLEAR, 8'hff, 32'hffff_ffff),
      word(OP_CHECK, 0, 0),
      word(OP_DESTROY, 0, 0),
      word(OP_CREATE, 0, 0),
      word(OP_CHECK, 0, 0),
      word(OP_CLEAR, 0, 0)
    };
    foreach (directed[i]) begin
      send_word(directed[i]);
    end
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_word(random_word(seg));
        sender_pause();
      end
      // hold off until every response of the segment is back
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_responses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
